// File: rtl/eth_ipv4_tcp_header_parser_macros.svh
// Assertion helpers for the header parser; all use clk and arst_n of the enclosing module.
`ifndef ETH_IPV4_TCP_HEADER_PARSER_MACROS_SVH
`define ETH_IPV4_TCP_HEADER_PARSER_MACROS_SVH

// same-cycle implication
`define EITP_ASSERT_IMP(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define EITP_ASSERT_NXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: rtl/eitp_pkg.sv
package eitp_pkg;

	localparam int PREVIEW_BYTES   = 32;
	localparam int MAX_FRAME_BYTES = 65535;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam int          ETH_HDR_LEN    = 14;
	localparam logic [5:0]  MIN_HDR_LEN    = 6'd20;

	localparam int OUT_DEPTH  = 4;
	localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
	localparam int OUT_LVL_W  = OUT_PTR_W + 1;
	localparam int OUT_DATA_W = 224;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOT_IPV4 = 2'd1,
		ST_NOT_TCP  = 2'd2,
		ST_TRUNC    = 2'd3
	} status_t;

	typedef enum logic {
		KIND_PREVIEW = 1'b0,
		KIND_SUMMARY = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t       result_kind;
		status_t     frame_status;
		logic [47:0] dest_mac;
		logic [47:0] source_mac;
		logic [31:0] source_ip;
		logic [31:0] dest_ip;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [15:0] payload_length;
		logic [7:0]  preview_char;
		logic        run_last;
	} result_t;

	typedef struct packed {
		logic [OUT_LVL_W-1:0] level;
		logic                 room;
	} fifo_stat_t;

	// header length as used for placing later fields
	function automatic logic [5:0] eff_len(input logic [5:0] len);
		return (len < MIN_HDR_LEN) ? MIN_HDR_LEN : len;
	endfunction

endpackage

// File: rtl/eitp_hdr_core.sv
module eitp_hdr_core import eitp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  logic [7:0]    frame_byte,
	input  logic          frame_last,
	output result_t       res_a,
	output result_t       res_b,
	output logic [1:0]    push_cnt
);

	logic [15:0] pos_q, pos_n;
	logic [5:0]  ip_q, ip_n;
	logic [5:0]  tcp_q, tcp_n;
	logic [7:0]  heo_q, heo_n;
	status_t     status_q, status_n;
	logic [47:0] dmac_q, dmac_n;
	logic [47:0] smac_q, smac_n;
	logic [7:0]  etype_hi_q, etype_hi_n;
	logic [31:0] sip_q, sip_n;
	logic [31:0] dip_q, dip_n;
	logic [31:0] ports_q, ports_n;

	logic [6:0]  tcp_start;
	logic [15:0] ts16;
	logic [15:0] pay_idx;
	logic        preview;
	logic [7:0]  pchar;
	status_t     st;
	logic [15:0] plen;
	result_t     prev_item, summ_item;

	always_comb begin
		pos_n      = pos_q;
		ip_n       = ip_q;
		tcp_n      = tcp_q;
		heo_n      = heo_q;
		status_n   = status_q;
		dmac_n     = dmac_q;
		smac_n     = smac_q;
		etype_hi_n = etype_hi_q;
		sip_n      = sip_q;
		dip_n      = dip_q;
		ports_n    = ports_q;
		preview    = 1'b0;

		tcp_start = 7'(ETH_HDR_LEN) + {1'b0, eff_len(ip_q)};
		ts16      = {9'd0, tcp_start};
		pay_idx   = pos_q - {8'd0, heo_q};

		if (pos_q < 16'(MAX_FRAME_BYTES)) begin
			if (pos_q < 16'd6) begin
				dmac_n = {dmac_q[39:0], frame_byte};
			end else if (pos_q < 16'd12) begin
				smac_n = {smac_q[39:0], frame_byte};
			end else if (pos_q == 16'd12) begin
				etype_hi_n = frame_byte;
			end else if (pos_q == 16'd13) begin
				if ({etype_hi_q, frame_byte} != ETHERTYPE_IPV4) begin
					status_n = ST_NOT_IPV4;
				end
			end else if (pos_q == 16'd14) begin
				ip_n = {frame_byte[3:0], 2'b00};
			end else if (pos_q == 16'd23) begin
				if (status_q == ST_OK && frame_byte != PROTO_TCP) begin
					status_n = ST_NOT_TCP;
				end
			end else if (pos_q >= 16'd26 && pos_q < 16'd30) begin
				sip_n = {sip_q[23:0], frame_byte};
			end else if (pos_q >= 16'd30 && pos_q < 16'd34) begin
				dip_n = {dip_q[23:0], frame_byte};
			end

			// TCP header sits at 34 or later, so no extra lower bound needed
			if (pos_q >= ts16 && pos_q < ts16 + 16'd4) begin
				ports_n = {ports_q[23:0], frame_byte};
			end
			if (pos_q == ts16 + 16'd12) begin
				tcp_n = {frame_byte[7:4], 2'b00};
				heo_n = {1'b0, tcp_start} + {2'b00, eff_len(tcp_n)};
			end

			preview = (heo_q != 8'd0) && (pos_q >= {8'd0, heo_q}) &&
				(pay_idx < 16'(PREVIEW_BYTES)) && (status_q == ST_OK) &&
				(ip_q >= MIN_HDR_LEN) && (tcp_q >= MIN_HDR_LEN);
			pos_n = pos_q + 16'd1;
		end
	end

	assign pchar = (frame_byte >= 8'h20 && frame_byte <= 8'h7E) ? frame_byte : 8'h2E;

	// summary status from the state including this item
	always_comb begin
		priority if (pos_n < 16'(ETH_HDR_LEN))                   st = ST_TRUNC;
		else if (status_n == ST_NOT_IPV4)                         st = ST_NOT_IPV4;
		else if (pos_n < 16'd24)                                  st = ST_TRUNC;
		else if (status_n == ST_NOT_TCP)                          st = ST_NOT_TCP;
		else if (ip_n < MIN_HDR_LEN)                              st = ST_TRUNC;
		else if (heo_n == 8'd0 || pos_n < {8'd0, heo_n})          st = ST_TRUNC;
		else if (tcp_n < MIN_HDR_LEN)                             st = ST_TRUNC;
		else                                                      st = ST_OK;
	end

	assign plen = (st == ST_OK) ? (pos_n - {8'd0, heo_n}) : 16'd0;

	always_comb begin
		prev_item              = '0;
		prev_item.result_kind  = KIND_PREVIEW;
		prev_item.preview_char = pchar;

		summ_item                = '0;
		summ_item.result_kind    = KIND_SUMMARY;
		summ_item.frame_status   = st;
		summ_item.dest_mac       = dmac_n;
		summ_item.source_mac     = smac_n;
		summ_item.source_ip      = sip_n;
		summ_item.dest_ip        = dip_n;
		summ_item.source_port    = ports_n[31:16];
		summ_item.dest_port      = ports_n[15:0];
		summ_item.payload_length = plen;
		summ_item.run_last       = 1'b1;

		res_b = '0;
		if (preview) begin
			res_a    = prev_item;
			res_b    = summ_item;
			push_cnt = frame_last ? 2'd2 : 2'd1;
		end else begin
			res_a    = summ_item;
			push_cnt = frame_last ? 2'd1 : 2'd0;
		end
		if (!fire) begin
			push_cnt = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			ip_q       <= '0;
			tcp_q      <= '0;
			heo_q      <= '0;
			status_q   <= ST_OK;
			dmac_q     <= '0;
			smac_q     <= '0;
			etype_hi_q <= '0;
			sip_q      <= '0;
			dip_q      <= '0;
			ports_q    <= '0;
		end else if (fire) begin
			if (frame_last) begin
				pos_q      <= '0;
				ip_q       <= '0;
				tcp_q      <= '0;
				heo_q      <= '0;
				status_q   <= ST_OK;
				dmac_q     <= '0;
				smac_q     <= '0;
				etype_hi_q <= '0;
				sip_q      <= '0;
				dip_q      <= '0;
				ports_q    <= '0;
			end else begin
				pos_q      <= pos_n;
				ip_q       <= ip_n;
				tcp_q      <= tcp_n;
				heo_q      <= heo_n;
				status_q   <= status_n;
				dmac_q     <= dmac_n;
				smac_q     <= smac_n;
				etype_hi_q <= etype_hi_n;
				sip_q      <= sip_n;
				dip_q      <= dip_n;
				ports_q    <= ports_n;
			end
		end
	end

endmodule

// File: rtl/eitp_out_fifo.sv
module eitp_out_fifo import eitp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_cnt,
	input  result_t    in_a,
	input  result_t    in_b,
	input  logic       pop,
	output result_t    head,
	output fifo_stat_t stat
);

	result_t              mem_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_q, rd_q;
	logic [OUT_LVL_W-1:0] level_q;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_q] <= in_a;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_q + OUT_PTR_W'(1)] <= in_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			wr_q    <= wr_q + OUT_PTR_W'(push_cnt);
			rd_q    <= rd_q + OUT_PTR_W'(pop);
			level_q <= level_q + OUT_LVL_W'(push_cnt) - OUT_LVL_W'(pop);
		end
	end

	assign head       = mem_q[rd_q];
	assign stat.level = level_q;
	// one item may push two results, so keep two slots free
	assign stat.room  = (level_q <= OUT_LVL_W'(OUT_DEPTH - 2));

endmodule

// File: rtl/eth_ipv4_tcp_header_parser.sv
// Throughput: one byte per cycle while the result queue has room for two results;
// the 4-entry result queue absorbs the one case where a byte yields two results
// (a preview byte that also closes the frame).
// Reset: arst_n clears frame state, the input stage and the result queue at once;
// the block is ready for bytes as soon as reset is released.
`include "eth_ipv4_tcp_header_parser_macros.svh"

module eth_ipv4_tcp_header_parser import eitp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] frame_byte
	input  logic                  s_tlast,   // frame_last
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [1:0] frame_status, [49:2] dest_mac, [97:50] source_mac,
	// [129:98] source_ip, [161:130] dest_ip, [177:162] source_port,
	// [193:178] dest_port, [209:194] payload_length, [217:210] preview_char,
	// [223:218] zero
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tuser,   // result_kind
	output logic                  m_tlast    // run_last
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic       advance;
	logic [1:0] push_cnt;
	result_t    res_a, res_b, head;
	fifo_stat_t stat;

	// the stage moves on only if the queue can take both possible results
	assign advance  = valid_s1 && stat.room;
	assign s_tready = !valid_s1 || stat.room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// field capture, status and preview decisions
	eitp_hdr_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (advance),
		.frame_byte (byte_s1),
		.frame_last (last_s1),
		.res_a      (res_a),
		.res_b      (res_b),
		.push_cnt   (push_cnt)
	);

	// result queue doubles as the output register
	eitp_out_fifo u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (push_cnt),
		.in_a     (res_a),
		.in_b     (res_b),
		.pop      (m_tvalid && m_tready),
		.head     (head),
		.stat     (stat)
	);

	assign m_tvalid = (stat.level != '0);
	assign m_tdata  = {6'd0, head.preview_char, head.payload_length, head.dest_port,
		head.source_port, head.dest_ip, head.source_ip, head.source_mac,
		head.dest_mac, head.frame_status};
	assign m_tuser  = head.result_kind;
	assign m_tlast  = head.run_last;

	`EITP_ASSERT_IMP(a_level_bound, 1'b1, stat.level <= OUT_LVL_W'(OUT_DEPTH), "result queue overflow")
	`EITP_ASSERT_NXT(a_last_gives_result, advance && last_s1, m_tvalid, "frame end produced no summary")
	`EITP_ASSERT_IMP(a_summary_closes, m_tvalid && m_tuser, m_tlast, "summary without run_last")
	`EITP_ASSERT_IMP(a_preview_clean, m_tvalid && !m_tuser, m_tdata[209:0] == '0 && !m_tlast, "preview item carries header fields")

endmodule

// File: tb/tb.sv
module tb;
	import eitp_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_BYTES = 700;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS  = 10;

	// fixed offsets inside the frame
	localparam int ETYPE_LAST = 13;
	localparam int IHL_POS    = 14;
	localparam int PROTO_POS  = 23;
	localparam int SIP_POS    = 26;
	localparam int DIP_POS    = 30;
	localparam int IP_FIXED   = 34;
	localparam int DOFF_POS   = 12;    // within the TCP header
	localparam int IP_PROTO_IDX = 9;   // within the IP header

	logic                  clk;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata  = '0;
	logic                  s_tlast  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;

	eth_ipv4_tcp_header_parser u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// shared run state
	logic       no_idle  = 1'b0;
	logic       hold_req = 1'b0;
	int         cycles;
	int         mismatches;
	int         bytes_sent;
	int         frames_sent;
	int         previews_seen;
	int         summaries_seen;
	int         in_stall_cycles;
	int         status_seen [4];
	logic [7:0] frame_buf [$];
	result_t    due_records [$];

	// predictor state: mirrors the parser's per-frame registers
	logic [15:0] frame_pos;
	logic [5:0]  ip_hlen;
	logic [5:0]  tcp_hlen;
	logic [7:0]  hdr_end;
	status_t     frame_state;
	logic [47:0] cap_dmac;
	logic [47:0] cap_smac;
	logic [15:0] cap_etype;
	logic [31:0] cap_sip;
	logic [31:0] cap_dip;
	logic [31:0] cap_ports;

	// short lengths still occupy a minimal header when placing later fields
	function automatic int hdr_span(input logic [5:0] n);
		if (n < MIN_HDR_LEN)
			return int'(MIN_HDR_LEN);
		return int'(n);
	endfunction

	function automatic void clear_capture();
		frame_pos   = '0;
		ip_hlen     = '0;
		tcp_hlen    = '0;
		hdr_end     = '0;
		frame_state = ST_OK;
		cap_dmac    = '0;
		cap_smac    = '0;
		cap_etype   = '0;
		cap_sip     = '0;
		cap_dip     = '0;
		cap_ports   = '0;
	endfunction

	// one accepted byte: update capture, queue a preview and/or a summary
	function automatic void parse_frame_byte(input logic [7:0] b, input logic last);
		int unsigned pos;
		int unsigned ts;
		int unsigned cnt;
		status_t     st;
		result_t     r;

		pos = frame_pos;
		if (pos < MAX_FRAME_BYTES) begin
			if (pos < 6)
				cap_dmac = {cap_dmac[39:0], b};
			else if (pos < 12)
				cap_smac = {cap_smac[39:0], b};
			else if (pos < ETH_HDR_LEN) begin
				cap_etype = {cap_etype[7:0], b};
				if (pos == ETYPE_LAST && cap_etype != ETHERTYPE_IPV4)
					frame_state = ST_NOT_IPV4;
			end else if (pos == IHL_POS)
				ip_hlen = {b[3:0], 2'b00};
			else if (pos == PROTO_POS) begin
				if (frame_state == ST_OK && b != PROTO_TCP)
					frame_state = ST_NOT_TCP;
			end else if (pos >= SIP_POS && pos < DIP_POS)
				cap_sip = {cap_sip[23:0], b};
			else if (pos >= DIP_POS && pos < IP_FIXED)
				cap_dip = {cap_dip[23:0], b};

			if (pos >= IP_FIXED) begin
				ts = ETH_HDR_LEN + hdr_span(ip_hlen);
				if (pos >= ts && pos < ts + 4)
					cap_ports = {cap_ports[23:0], b};
				if (pos == ts + DOFF_POS) begin
					tcp_hlen = {b[7:4], 2'b00};
					hdr_end  = 8'(ts + hdr_span(tcp_hlen));
				end
			end

			// payload preview only for clean TCP frames
			if (hdr_end != 0 && pos >= hdr_end && pos - hdr_end < PREVIEW_BYTES &&
					frame_state == ST_OK && ip_hlen >= MIN_HDR_LEN &&
					tcp_hlen >= MIN_HDR_LEN) begin
				r = '0;
				r.result_kind  = KIND_PREVIEW;
				r.preview_char = (b >= 8'h20 && b <= 8'h7E) ? b : 8'h2E;
				due_records.push_back(r);
			end
			frame_pos = 16'(pos + 1);
		end

		if (last) begin
			cnt = frame_pos;
			if (cnt < ETH_HDR_LEN)
				st = ST_TRUNC;
			else if (frame_state == ST_NOT_IPV4)
				st = ST_NOT_IPV4;
			else if (cnt < PROTO_POS + 1)
				st = ST_TRUNC;
			else if (frame_state == ST_NOT_TCP)
				st = ST_NOT_TCP;
			else if (ip_hlen < MIN_HDR_LEN)
				st = ST_TRUNC;
			else if (hdr_end == 0 || cnt < hdr_end)
				st = ST_TRUNC;
			else if (tcp_hlen < MIN_HDR_LEN)
				st = ST_TRUNC;
			else
				st = ST_OK;

			r = '0;
			r.result_kind  = KIND_SUMMARY;
			r.frame_status = st;
			r.dest_mac     = cap_dmac;
			r.source_mac   = cap_smac;
			r.source_ip    = cap_sip;
			r.dest_ip      = cap_dip;
			r.source_port  = cap_ports[31:16];
			r.dest_port    = cap_ports[15:0];
			r.run_last     = 1'b1;
			if (st == ST_OK)
				r.payload_length = (cnt - hdr_end > 32'hFFFF) ? 16'hFFFF : 16'(cnt - hdr_end);
			due_records.push_back(r);
			clear_capture();
		end
	endfunction

	function automatic void count_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("[%0d] %s", cycles, what);
	endfunction

	function automatic void check_field(input string name, input logic [47:0] want,
			input logic [47:0] got);
		if (got !== want)
			count_mismatch($sformatf("%s: expected %h, got %h", name, want, got));
	endfunction

	// result checker
	result_t want_rec;
	result_t seen_rec;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && s_tvalid && !s_tready)
			in_stall_cycles++;
		if (arst_n && m_tvalid && m_tready) begin
			seen_rec.result_kind    = kind_t'(m_tuser);
			seen_rec.frame_status   = status_t'(m_tdata[1:0]);
			seen_rec.dest_mac       = m_tdata[49:2];
			seen_rec.source_mac     = m_tdata[97:50];
			seen_rec.source_ip      = m_tdata[129:98];
			seen_rec.dest_ip        = m_tdata[161:130];
			seen_rec.source_port    = m_tdata[177:162];
			seen_rec.dest_port      = m_tdata[193:178];
			seen_rec.payload_length = m_tdata[209:194];
			seen_rec.preview_char   = m_tdata[217:210];
			seen_rec.run_last       = m_tlast;
			if (due_records.size() == 0)
				count_mismatch("result item with nothing expected");
			else begin
				want_rec = due_records.pop_front();
				check_field("result_kind", 48'(want_rec.result_kind),
					48'(seen_rec.result_kind));
				check_field("frame_status", 48'(want_rec.frame_status),
					48'(seen_rec.frame_status));
				check_field("dest_mac", want_rec.dest_mac, seen_rec.dest_mac);
				check_field("source_mac", want_rec.source_mac, seen_rec.source_mac);
				check_field("source_ip", 48'(want_rec.source_ip), 48'(seen_rec.source_ip));
				check_field("dest_ip", 48'(want_rec.dest_ip), 48'(seen_rec.dest_ip));
				check_field("source_port", 48'(want_rec.source_port),
					48'(seen_rec.source_port));
				check_field("dest_port", 48'(want_rec.dest_port), 48'(seen_rec.dest_port));
				check_field("payload_length", 48'(want_rec.payload_length),
					48'(seen_rec.payload_length));
				check_field("preview_char", 48'(want_rec.preview_char),
					48'(seen_rec.preview_char));
				check_field("run_last", 48'(want_rec.run_last), 48'(seen_rec.run_last));
				if (want_rec.result_kind == KIND_SUMMARY) begin
					summaries_seen++;
					status_seen[want_rec.frame_status]++;
				end else
					previews_seen++;
			end
		end
	end

	// receiver: short random stalls, a few long ones, and a long hold on request
	initial begin
		int stall_left;
		int hold_left;

		stall_left = 0;
		hold_left  = 0;
		forever begin
			@(posedge clk);
			if (hold_req)
				hold_left = HOLD_CYCLES;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!no_idle && $urandom_range(0, 3) == 0)
					stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
						: $urandom_range(1, 3);
			end
		end
	end

	// watchdog
	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int draw_gap();
		int r;

		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;

		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		parse_frame_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_buf.size(); i++)
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
		frames_sent++;
	endtask

	task automatic stream_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// Ethernet + IPv4 + TCP frame with random field content; options pad the
	// headers out to the lengths the IHL and data offset nibbles give, at least 20 bytes
	task automatic build_frame(input logic [15:0] etype, input logic [7:0] proto,
			input logic [3:0] ihl, input logic [3:0] doff, input int pay_bytes);
		int ip_len;
		int tcp_len;

		frame_buf.delete();
		repeat (12) frame_buf.push_back(8'($urandom));
		frame_buf.push_back(etype[15:8]);
		frame_buf.push_back(etype[7:0]);
		frame_buf.push_back({4'($urandom), ihl});
		ip_len = hdr_span({ihl, 2'b00});
		for (int i = 1; i < ip_len; i++)
			frame_buf.push_back((i == IP_PROTO_IDX) ? proto : 8'($urandom));
		tcp_len = hdr_span({doff, 2'b00});
		for (int i = 0; i < tcp_len; i++)
			frame_buf.push_back((i == DOFF_POS) ? {doff, 4'($urandom)} : 8'($urandom));
		repeat (pay_bytes) frame_buf.push_back(8'($urandom));
	endtask

	task automatic trim_frame(input int len);
		while (frame_buf.size() > len)
			void'(frame_buf.pop_back());
	endtask

	task automatic test_well_formed();
		logic [7:0] edge_chars [8];

		edge_chars = '{8'h00, 8'h1F, 8'h20, 8'h41, 8'h7E, 8'h7F, 8'h80, 8'hFF};
		// printable boundaries; frame closes on a preview byte (two results)
		build_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd5, 4'd5, 0);
		foreach (edge_chars[i])
			frame_buf.push_back(edge_chars[i]);
		send_frame();
		// largest headers, payload beyond the preview window
		build_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd15, 4'd15, 40);
		send_frame();
		// headers only, zero payload
		build_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd5, 4'd5, 0);
		send_frame();
		// all-ones and all-zero addresses and ports
		build_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd5, 4'd5, 3);
		for (int i = 0; i < 12; i++)
			frame_buf[i] = 8'hFF;
		for (int i = SIP_POS; i < IP_FIXED + 4; i++)
			frame_buf[i] = 8'hFF;
		send_frame();
		build_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd5, 4'd5, 3);
		for (int i = 0; i < 12; i++)
			frame_buf[i] = 8'h00;
		for (int i = SIP_POS; i < IP_FIXED + 4; i++)
			frame_buf[i] = 8'h00;
		send_frame();
	endtask

	task automatic test_rejects();
		build_frame(16'h86DD, PROTO_TCP, 4'd5, 4'd5, 6);   // not IPv4
		send_frame();
		build_frame(ETHERTYPE_IPV4, 8'd17, 4'd5, 4'd5, 6);  // UDP
		send_frame();
		build_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd0, 4'd5, 6);  // IHL too short
		send_frame();
		build_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd4, 4'd5, 6);
		send_frame();
		build_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd5, 4'd4, 6);  // data offset too short
		send_frame();
		build_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd5, 4'd0, 6);
		send_frame();
		// priority: bad EtherType wins over bad protocol and IHL
		build_frame(16'h0806, 8'd1, 4'd2, 4'd5, 2);
		send_frame();
		// priority: bad protocol wins over bad IHL
		build_frame(ETHERTYPE_IPV4, 8'd255, 4'd3, 4'd5, 2);
		send_frame();
	endtask

	task automatic test_truncation();
		int cuts [8];

		// inside the destination MAC, inside EtherType, at its end, before/at protocol,
		// mid-IP, mid-ports, one short of the TCP header
		cuts = '{1, 13, 14, 23, 24, 30, 37, 53};
		foreach (cuts[i]) begin
			build_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd5, 4'd5, 4);
			trim_frame(cuts[i]);
			send_frame();
		end
		// short frame, but the EtherType already says not IPv4
		build_frame(16'h0000, PROTO_TCP, 4'd5, 4'd5, 0);
		trim_frame(ETH_HDR_LEN);
		send_frame();
		// long IP header, frame ends inside the options
		build_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd15, 4'd5, 0);
		trim_frame(60);
		send_frame();
	endtask

	// receiver holds off while a full preview burst streams in
	task automatic test_pressure();
		no_idle <= 1'b1;
		stream_idle();
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		build_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd5, 4'd5, PREVIEW_BYTES);
		send_frame();
		no_idle <= 1'b0;
	endtask

	// bytes past the maximum frame size are dropped, the last flag still closes it
	task automatic test_long_frame();
		stream_idle();
		no_idle <= 1'b1;
		build_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd5, 4'd5, MAX_FRAME_BYTES + 3 - 54);
		send_frame();
		frame_buf.delete();
		no_idle <= 1'b0;
	endtask

	task automatic test_random_traffic();
		int          start_bytes;
		int          pick;
		int          plen;
		logic [15:0] et;
		logic [7:0]  pr;
		logic [3:0]  ihl;
		logic [3:0]  doff;

		stream_idle();
		start_bytes = bytes_sent;
		while (bytes_sent - start_bytes < RANDOM_BYTES) begin
			if ($urandom_range(0, 6) == 0)
				no_idle <= ~no_idle;
			pick = $urandom_range(0, 99);
			et   = ETHERTYPE_IPV4;
			pr   = PROTO_TCP;
			ihl  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
			doff = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
			plen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			if (pick >= 65 && pick < 75) begin
				case ($urandom_range(0, 3))
					0: et = 16'($urandom);
					1: pr = 8'($urandom);
					2: ihl = 4'($urandom_range(0, 4));
					default: doff = 4'($urandom_range(0, 4));
				endcase
			end
			if (pick < 90) begin
				build_frame(et, pr, ihl, doff, plen);
				if (pick >= 75)
					trim_frame($urandom_range(1, frame_buf.size()));
			end else begin
				// raw noise
				frame_buf.delete();
				repeat ($urandom_range(1, 40)) frame_buf.push_back(8'($urandom));
			end
			send_frame();
		end
		no_idle <= 1'b0;
	endtask

	initial begin
		cycles          = 0;
		mismatches      = 0;
		bytes_sent      = 0;
		frames_sent     = 0;
		previews_seen   = 0;
		summaries_seen  = 0;
		in_stall_cycles = 0;
		foreach (status_seen[i])
			status_seen[i] = 0;
		clear_capture();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_well_formed();
		test_rejects();
		test_truncation();
		test_pressure();
		test_long_frame();
		test_random_traffic();
		stream_idle();

		while (due_records.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d frames / %0d bytes incl. one oversize frame; input stalled %0d cycles.",
			frames_sent, bytes_sent, in_stall_cycles);
		$display("Checked %0d previews, %0d summaries (ok %0d, non-IPv4 %0d, non-TCP %0d, short %0d).",
			previews_seen, summaries_seen, status_seen[ST_OK], status_seen[ST_NOT_IPV4],
			status_seen[ST_NOT_TCP], status_seen[ST_TRUNC]);
		if (mismatches == 0 && due_records.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
